// ===== rtl/bba_pkg.sv =====
`default_nettype none
package bba_pkg;

    localparam int HEAP_BYTES = 8192;
    localparam int MIN_BLOCK  = 64;
    localparam int LEAF_LVL   = 7;
    localparam int NODES      = 255;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_REALLOC = 2'd2;

    localparam logic [1:0] ST_EMPTY   = 2'd0;
    localparam logic [1:0] ST_PARTIAL = 2'd1;
    localparam logic [1:0] ST_ALLOC   = 2'd2;

    localparam logic [1:0] RS_OK    = 2'd0;
    localparam logic [1:0] RS_NOBLK = 2'd1;
    localparam logic [1:0] RS_MISS  = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [13:0] request_size;
        logic [12:0] block_offset;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [12:0] result_offset;
        logic [13:0] copy_length;
    } t_out;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_FETCH = 8'b00000010,
        S_EVAL  = 8'b00000100,
        S_UP    = 8'b00001000,
        S_SIB   = 8'b00010000,
        S_MERGE = 8'b00100000,
        S_REL   = 8'b01000000,
        S_DONE  = 8'b10000000
    } t_state;

    typedef enum logic [1:0] {
        SEG_FIND  = 2'd0,
        SEG_ALLOC = 2'd1,
        SEG_FREE  = 2'd2
    } t_seg;

    // Node size in bytes at a tree level.
    function automatic logic [13:0] node_size(input logic [2:0] lvl);
        node_size = 14'(HEAP_BYTES >> lvl);
    endfunction

    // Deepest level whose node size still holds the request, capped at the leaves.
    function automatic logic [2:0] target_level(input logic [13:0] req);
        logic [2:0] l;
        l = 3'(LEAF_LVL);
        for (int i = LEAF_LVL; i >= 0; i--) begin
            if ({1'b0, node_size(3'(i))} < {req, 1'b0}) begin
                l = 3'(i);
            end
        end
        target_level = l;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/bba_ram.sv =====
`default_nettype none
module bba_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 255,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one entry, register the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/buddy_block_allocator.sv =====
// Buddy allocator over an 8 KiB heap, 64-byte minimum block, tree of 255 nodes.
// Input channel i_valid/o_ready carries one request transaction (op, size,
// offset); output channel o_valid/i_ready returns one result per request.
// The block takes one request at a time: o_ready is high only when idle.
// Each node visit reads the node-state RAM, so the time taken is set by the
// tree walk: a free or size lookup walks down level by level, then a free
// that hits merges back up to the root. An allocate walks depth-first with
// backtracking, then marks its ancestors on the way back to the root; the walk
// is longer when the heap is fragmented. Reallocate chains a lookup, an
// allocate and a free; a zero size only frees. Reset clears the state
// machine and the 255 node valid bits, so every node reads as empty at once.
// A result stays on o_data with o_valid high until i_ready takes it; no new
// request is taken meanwhile.
`default_nettype none
module buddy_block_allocator (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire bba_pkg::t_in  i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output bba_pkg::t_out      o_data
);

    bba_pkg::t_state r_state, n_state;
    bba_pkg::t_seg   r_seg, n_seg;
    logic [1:0]  r_op, n_op;
    logic [13:0] r_req, n_req;
    logic [12:0] r_off, n_off;
    logic [2:0]  r_tlvl, n_tlvl;
    logic [7:0]  r_pos, n_pos;
    logic [2:0]  r_lvl, n_lvl;
    logic [12:0] r_start, n_start;
    logic [1:0]  r_cur, n_cur;
    logic [7:0]  r_old_pos, n_old_pos;
    logic [13:0] r_old_size, n_old_size;
    logic [1:0]  r_status, n_status;
    logic [12:0] r_res, n_res;
    logic [13:0] r_copy, n_copy;
    logic [bba_pkg::NODES-1:0] r_valid;
    logic        r_rd_vld;

    logic        we;
    logic [7:0]  waddr;
    logic [1:0]  wdata;
    logic [7:0]  raddr;
    logic [1:0]  ram_q;
    logic [1:0]  node_st;
    logic [13:0] lvl_size;
    logic        hit;
    logic        bit_up;
    logic [1:0]  par;
    logic [13:0] min_len;

    bba_ram #(.WIDTH(2), .DEPTH(bba_pkg::NODES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(ram_q)
    );

    assign node_st  = r_rd_vld ? ram_q : bba_pkg::ST_EMPTY;
    assign lvl_size = bba_pkg::node_size(r_lvl);
    assign hit      = (node_st == bba_pkg::ST_ALLOC) && (r_off == r_start);
    assign bit_up   = r_off[4'd12 - {1'b0, r_lvl}];
    assign par      = (r_cur == bba_pkg::ST_EMPTY && node_st == bba_pkg::ST_EMPTY)
                      ? bba_pkg::ST_EMPTY : bba_pkg::ST_PARTIAL;
    assign min_len  = (r_req < r_old_size) ? r_req : r_old_size;

    assign o_ready = (r_state == bba_pkg::S_IDLE);
    assign o_valid = (r_state == bba_pkg::S_DONE);
    assign o_data  = '{status: r_status, result_offset: r_res, copy_length: r_copy};

    // Sequence the tree walk
    always_comb begin
        n_state    = r_state;
        n_seg      = r_seg;
        n_op       = r_op;
        n_req      = r_req;
        n_off      = r_off;
        n_tlvl     = r_tlvl;
        n_pos      = r_pos;
        n_lvl      = r_lvl;
        n_start    = r_start;
        n_cur      = r_cur;
        n_old_pos  = r_old_pos;
        n_old_size = r_old_size;
        n_status   = r_status;
        n_res      = r_res;
        n_copy     = r_copy;
        we         = 1'b0;
        waddr      = r_pos - 8'd1;
        wdata      = bba_pkg::ST_EMPTY;
        raddr      = 8'd0;

        case (r_state)
            bba_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_op       = i_data.op;
                    n_req      = i_data.request_size;
                    n_off      = i_data.block_offset;
                    n_tlvl     = bba_pkg::target_level(i_data.request_size);
                    n_pos      = 8'd1;
                    n_lvl      = 3'd0;
                    n_start    = 13'd0;
                    n_old_size = 14'd0;
                    n_old_pos  = 8'd1;
                    n_status   = bba_pkg::RS_NOBLK;
                    n_res      = 13'd0;
                    n_copy     = 14'd0;
                    case (i_data.op)
                        bba_pkg::OP_ALLOC: begin
                            n_seg = bba_pkg::SEG_ALLOC;
                            if (i_data.request_size == 14'd0 ||
                                i_data.request_size > 14'(bba_pkg::HEAP_BYTES)) begin
                                n_state = bba_pkg::S_DONE;
                            end else begin
                                n_state = bba_pkg::S_FETCH;
                            end
                        end
                        bba_pkg::OP_FREE, bba_pkg::OP_REALLOC: begin
                            n_seg   = bba_pkg::SEG_FIND;
                            n_state = bba_pkg::S_FETCH;
                        end
                        default: n_state = bba_pkg::S_DONE;
                    endcase
                end
            end

            bba_pkg::S_FETCH: begin
                raddr   = r_pos - 8'd1;
                n_state = bba_pkg::S_EVAL;
            end

            bba_pkg::S_EVAL: begin
                if (r_seg == bba_pkg::SEG_ALLOC) begin
                    if (r_lvl == r_tlvl) begin
                        if (node_st == bba_pkg::ST_EMPTY) begin
                            // Grant this node, then mark ancestors partial
                            we      = 1'b1;
                            wdata   = bba_pkg::ST_ALLOC;
                            n_cur   = bba_pkg::ST_ALLOC;
                            n_res   = r_start;
                            n_state = bba_pkg::S_SIB;
                            if (r_op == bba_pkg::OP_ALLOC || r_old_size != 14'd0) begin
                                n_status = bba_pkg::RS_OK;
                                n_copy   = (r_op == bba_pkg::OP_ALLOC) ? 14'd0 : min_len;
                            end else begin
                                n_status = bba_pkg::RS_MISS;
                            end
                        end else begin
                            n_state = bba_pkg::S_UP;
                        end
                    end else if (node_st == bba_pkg::ST_ALLOC) begin
                        n_state = bba_pkg::S_UP;
                    end else begin
                        n_pos   = {r_pos[6:0], 1'b0};
                        n_lvl   = r_lvl + 3'd1;
                        n_state = bba_pkg::S_FETCH;
                    end
                end else if (node_st != bba_pkg::ST_ALLOC && r_lvl != 3'(bba_pkg::LEAF_LVL)) begin
                    // Descend toward the offset
                    n_pos   = {r_pos[6:0], bit_up};
                    n_lvl   = r_lvl + 3'd1;
                    n_start = bit_up ? r_start + 13'(lvl_size >> 1) : r_start;
                    n_state = bba_pkg::S_FETCH;
                end else if (r_op == bba_pkg::OP_FREE) begin
                    if (hit) begin
                        we       = 1'b1;
                        n_cur    = bba_pkg::ST_EMPTY;
                        n_seg    = bba_pkg::SEG_FREE;
                        n_status = bba_pkg::RS_OK;
                        n_state  = bba_pkg::S_SIB;
                    end else begin
                        n_status = bba_pkg::RS_MISS;
                        n_state  = bba_pkg::S_DONE;
                    end
                end else begin
                    // Reallocate: old block known, pick the next segment
                    n_old_pos  = r_pos;
                    n_old_size = hit ? lvl_size : 14'd0;
                    if (r_req == 14'd0) begin
                        if (hit) begin
                            we      = 1'b1;
                            n_cur   = bba_pkg::ST_EMPTY;
                            n_seg   = bba_pkg::SEG_FREE;
                            n_state = bba_pkg::S_SIB;
                        end else begin
                            n_state = bba_pkg::S_DONE;
                        end
                    end else if (r_req > 14'(bba_pkg::HEAP_BYTES)) begin
                        n_state = bba_pkg::S_DONE;
                    end else begin
                        n_seg   = bba_pkg::SEG_ALLOC;
                        n_pos   = 8'd1;
                        n_lvl   = 3'd0;
                        n_start = 13'd0;
                        n_state = bba_pkg::S_FETCH;
                    end
                end
            end

            bba_pkg::S_UP: begin
                // Backtrack: next sibling, or climb out of a right child
                if (r_pos == 8'd1) begin
                    n_state = bba_pkg::S_DONE;
                end else if (!r_pos[0]) begin
                    n_pos   = r_pos + 8'd1;
                    n_start = r_start + 13'(lvl_size);
                    n_state = bba_pkg::S_FETCH;
                end else begin
                    n_pos   = {1'b0, r_pos[7:1]};
                    n_lvl   = r_lvl - 3'd1;
                    n_start = r_start - 13'(lvl_size);
                end
            end

            bba_pkg::S_SIB: begin
                if (r_pos == 8'd1) begin
                    if (r_seg == bba_pkg::SEG_ALLOC && r_op == bba_pkg::OP_REALLOC &&
                        r_old_size != 14'd0) begin
                        n_state = bba_pkg::S_REL;
                    end else begin
                        n_state = bba_pkg::S_DONE;
                    end
                end else begin
                    raddr   = (r_pos ^ 8'd1) - 8'd1;
                    n_state = bba_pkg::S_MERGE;
                end
            end

            bba_pkg::S_MERGE: begin
                // Write the parent from both children
                we      = 1'b1;
                waddr   = {1'b0, r_pos[7:1]} - 8'd1;
                wdata   = par;
                n_cur   = par;
                n_pos   = {1'b0, r_pos[7:1]};
                n_state = bba_pkg::S_SIB;
            end

            bba_pkg::S_REL: begin
                // Free the old block after the new grant
                we      = 1'b1;
                waddr   = r_old_pos - 8'd1;
                n_pos   = r_old_pos;
                n_cur   = bba_pkg::ST_EMPTY;
                n_seg   = bba_pkg::SEG_FREE;
                n_state = bba_pkg::S_SIB;
            end

            bba_pkg::S_DONE: begin
                if (i_ready) begin
                    n_state = bba_pkg::S_IDLE;
                end
            end

            default: n_state = bba_pkg::S_IDLE;
        endcase
    end

    // Hold control state and node valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bba_pkg::S_IDLE;
            r_seg   <= bba_pkg::SEG_FIND;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            r_seg   <= n_seg;
            if (we) begin
                r_valid[waddr] <= 1'b1;
            end
        end
    end

    // Advance the walk registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_req      <= n_req;
        r_off      <= n_off;
        r_tlvl     <= n_tlvl;
        r_pos      <= n_pos;
        r_lvl      <= n_lvl;
        r_start    <= n_start;
        r_cur      <= n_cur;
        r_old_pos  <= n_old_pos;
        r_old_size <= n_old_size;
        r_status   <= n_status;
        r_res      <= n_res;
        r_copy     <= n_copy;
        r_rd_vld   <= r_valid[raddr];
    end

endmodule
`default_nettype wire
